// ===== src/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg: buddy allocator shared definitions
// Arena geometry, free map layout, request and status codes, command type.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int TOP_ORDER       = 10;
  localparam int TOP_BLOCKS      = 32;
  localparam int MIN_BLOCK_BYTES = 128;
  localparam int HEADER_BYTES    = 32;
  localparam int SIZE_LIMIT      = 100000000;

  localparam int REQ_W   = 27;
  localparam int OFF_W   = 22;
  localparam int ORD_W   = 4;
  localparam int CNT_W   = 16;
  localparam int BYTES_W = 22;
  localparam int NEED_W  = REQ_W + 1;

  localparam int UNITS     = TOP_BLOCKS << TOP_ORDER;
  localparam int UNIT_W    = $clog2(UNITS);
  localparam int MIN_SHIFT = $clog2(MIN_BLOCK_BYTES);

  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = 5;

  localparam int QDEPTH = 2;
  localparam int Q_AW   = $clog2(QDEPTH);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  function automatic int order_words(int k);
    return ((TOP_BLOCKS << (TOP_ORDER - k)) + WORD_BITS - 1) / WORD_BITS;
  endfunction

  function automatic int calc_map_words();
    int s;
    s = 0;
    for (int k = 0; k <= TOP_ORDER; k++) s += order_words(k);
    return s;
  endfunction

  localparam int MAP_WORDS = calc_map_words();
  localparam int MAP_AW    = $clog2(MAP_WORDS);
  localparam int CLR_N     = (UNITS > MAP_WORDS) ? UNITS : MAP_WORDS;
  localparam int CLR_W     = $clog2(CLR_N);

  typedef logic [MAP_AW-1:0] map_addr_t;
  typedef logic [UNIT_W-1:0] unit_t;
  typedef logic [ORD_W-1:0]  order_t;
  typedef map_addr_t base_arr_t [0:TOP_ORDER];

  function automatic base_arr_t calc_base();
    base_arr_t b;
    int s;
    s = 0;
    for (int k = 0; k <= TOP_ORDER; k++) begin
      b[k] = MAP_AW'(s);
      s += order_words(k);
    end
    return b;
  endfunction

  localparam base_arr_t MAP_BASE = calc_base();

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_LARGE   = 3'd2,
    ST_OOM     = 3'd3,
    ST_BADFREE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_ERR
  } kind_t;

  typedef struct packed {
    kind_t   kind;
    status_t status;
    order_t  order;
    unit_t   unit;
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DISP,
    S_A_RD,
    S_A_CHK,
    S_A_SPLIT,
    S_SET_RD,
    S_SET_WR,
    S_F_INFO,
    S_F_LOOP,
    S_F_CHK,
    S_RES
  } bk_state_t;

  function automatic logic [BYTES_W-1:0] net_bytes(order_t k);
    return BYTES_W'((MIN_BLOCK_BYTES << k) - HEADER_BYTES);
  endfunction

  function automatic map_addr_t map_word(order_t k, unit_t u);
    return MAP_BASE[k] + MAP_AW'((u >> k) >> WORD_SHIFT);
  endfunction

  function automatic logic [WORD_SHIFT-1:0] map_bit(order_t k, unit_t u);
    unit_t s;
    s = u >> k;
    return s[WORD_SHIFT-1:0];
  endfunction

endpackage

// ===== src/bba_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_front: request classifier and command queue
// Sizes allocations to an order, screens requests, queues commands.
// ----------------------------------------------------------------------------
module bba_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_req_type,
  input  logic [bba_pkg::REQ_W-1:0]  in_request_bytes,
  input  logic [bba_pkg::OFF_W-1:0]  in_free_offset,
  output logic                       cmd_valid,
  output bba_pkg::cmd_t              cmd,
  input  logic                       cmd_pop
);

  logic [bba_pkg::NEED_W-1:0] need;
  logic                       ord_found;
  bba_pkg::order_t            ord;
  logic [bba_pkg::OFF_W-1:0]  off_units;
  bba_pkg::cmd_t              cls;

  bba_pkg::cmd_t              q_r [0:bba_pkg::QDEPTH-1];
  logic [bba_pkg::Q_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [bba_pkg::Q_AW:0]     cnt_r, cnt_nxt;
  logic                       push_ok;

  always_comb begin
    need = bba_pkg::NEED_W'(in_request_bytes) + bba_pkg::NEED_W'(bba_pkg::HEADER_BYTES);
    ord_found = 1'b0;
    ord = '0;
    for (int k = bba_pkg::TOP_ORDER; k >= 0; k--) begin
      if (bba_pkg::NEED_W'(bba_pkg::MIN_BLOCK_BYTES << k) >= need) begin
        ord_found = 1'b1;
        ord = bba_pkg::ORD_W'(k);
      end
    end
    off_units = in_free_offset >> bba_pkg::MIN_SHIFT;
    cls = '0;
    cls.unit = bba_pkg::UNIT_W'(off_units);
    if (in_req_type == bba_pkg::REQ_ALLOC) begin
      if (in_request_bytes == '0) begin
        cls.kind = bba_pkg::CMD_ERR;
        cls.status = bba_pkg::ST_ZERO;
      end else if (in_request_bytes > bba_pkg::REQ_W'(bba_pkg::SIZE_LIMIT) || !ord_found) begin
        cls.kind = bba_pkg::CMD_ERR;
        cls.status = bba_pkg::ST_LARGE;
      end else begin
        cls.kind = bba_pkg::CMD_ALLOC;
        cls.status = bba_pkg::ST_OK;
        cls.order = ord;
      end
    end else begin
      if (in_free_offset[bba_pkg::MIN_SHIFT-1:0] != '0 ||
          {1'b0, off_units} >= (bba_pkg::OFF_W+1)'(bba_pkg::UNITS)) begin
        cls.kind = bba_pkg::CMD_ERR;
        cls.status = bba_pkg::ST_BADFREE;
      end else begin
        cls.kind = bba_pkg::CMD_FREE;
        cls.status = bba_pkg::ST_OK;
      end
    end
  end

  assign in_full   = (cnt_r == (bba_pkg::Q_AW+1)'(bba_pkg::QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];
  assign push_ok   = in_push && !in_full;

  always_comb begin
    wp_nxt  = push_ok ? wp_r + 1'b1 : wp_r;
    rp_nxt  = (cmd_pop && cmd_valid) ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (bba_pkg::Q_AW+1)'(push_ok) - (bba_pkg::Q_AW+1)'(cmd_pop && cmd_valid);
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/bba_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_back: allocation engine
// Free map and block info memories, search, split, coalesce, result register.
// ----------------------------------------------------------------------------
module bba_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  bba_pkg::cmd_t                cmd,
  output logic                         cmd_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [2:0]                   out_status,
  output logic [bba_pkg::OFF_W-1:0]    out_block_offset,
  output logic [bba_pkg::ORD_W-1:0]    out_block_order,
  output logic [bba_pkg::CNT_W-1:0]    out_total_blocks,
  output logic [bba_pkg::CNT_W-1:0]    out_free_cnt,
  output logic [bba_pkg::BYTES_W-1:0]  out_free_total
);

  logic [bba_pkg::WORD_BITS-1:0] fm_mem [0:bba_pkg::MAP_WORDS-1];
  logic [bba_pkg::WORD_BITS-1:0] fm_rdata_r;
  bba_pkg::map_addr_t            fm_raddr, fm_waddr;
  logic                          fm_we;
  logic [bba_pkg::WORD_BITS-1:0] fm_wdata;

  logic [bba_pkg::ORD_W:0]       bi_mem [0:bba_pkg::UNITS-1];
  logic [bba_pkg::ORD_W:0]       bi_rdata_r;
  bba_pkg::unit_t                bi_raddr, bi_waddr;
  logic                          bi_we;
  logic [bba_pkg::ORD_W:0]       bi_wdata;

  bba_pkg::bk_state_t            state_r, state_nxt;
  bba_pkg::cmd_t                 cur_r, cur_nxt;
  bba_pkg::order_t               j_r, j_nxt, sk_r, sk_nxt;
  bba_pkg::map_addr_t            widx_r, widx_nxt, fa_r, fa_nxt;
  bba_pkg::unit_t                u_r, u_nxt, su_r, su_nxt, bud;
  logic [bba_pkg::WORD_SHIFT-1:0] fb_r, fb_nxt, low_bit;
  logic [bba_pkg::CLR_W-1:0]     clr_r, clr_nxt;
  logic [bba_pkg::CNT_W-1:0]     lvl_r [0:bba_pkg::TOP_ORDER];
  logic [bba_pkg::CNT_W-1:0]     lvl_nxt [0:bba_pkg::TOP_ORDER];
  logic [bba_pkg::CNT_W-1:0]     blk_r, blk_nxt, fcnt_r, fcnt_nxt;
  logic [bba_pkg::BYTES_W-1:0]   fbytes_r, fbytes_nxt;
  logic                          pick_found;
  bba_pkg::order_t               pick_j;

  logic                          res_valid_r, res_valid_nxt;
  bba_pkg::status_t              res_st_r, res_st_nxt;
  logic [bba_pkg::OFF_W-1:0]     res_off_r, res_off_nxt;
  bba_pkg::order_t               res_ord_r, res_ord_nxt;
  logic [bba_pkg::CNT_W-1:0]     res_blk_r, res_fcnt_r;
  logic [bba_pkg::BYTES_W-1:0]   res_fbytes_r;
  logic                          res_load;

  function automatic logic [bba_pkg::WORD_BITS-1:0] init_word(logic [bba_pkg::CLR_W-1:0] a);
    logic [bba_pkg::WORD_BITS-1:0] w;
    int rel;
    w = '0;
    rel = int'(a) - int'(bba_pkg::MAP_BASE[bba_pkg::TOP_ORDER]);
    for (int b = 0; b < bba_pkg::WORD_BITS; b++) begin
      if (rel >= 0 && rel * bba_pkg::WORD_BITS + b < bba_pkg::TOP_BLOCKS) w[b] = 1'b1;
    end
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (fm_we) fm_mem[fm_waddr] <= fm_wdata;
    fm_rdata_r <= fm_mem[fm_raddr];
  end

  always_ff @(posedge clk) begin
    if (bi_we) bi_mem[bi_waddr] <= bi_wdata;
    bi_rdata_r <= bi_mem[bi_raddr];
  end

  always_comb begin
    pick_found = 1'b0;
    pick_j = '0;
    for (int jj = bba_pkg::TOP_ORDER; jj >= 0; jj--) begin
      if (bba_pkg::ORD_W'(jj) >= cur_r.order && lvl_r[jj] != '0) begin
        pick_found = 1'b1;
        pick_j = bba_pkg::ORD_W'(jj);
      end
    end
    low_bit = '0;
    for (int b = bba_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (fm_rdata_r[b]) low_bit = bba_pkg::WORD_SHIFT'(b);
    end
    bud = u_r ^ (bba_pkg::UNIT_W'(1) << j_r);
  end

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    j_nxt      = j_r;
    sk_nxt     = sk_r;
    widx_nxt   = widx_r;
    fa_nxt     = fa_r;
    u_nxt      = u_r;
    su_nxt     = su_r;
    fb_nxt     = fb_r;
    clr_nxt    = clr_r;
    lvl_nxt    = lvl_r;
    blk_nxt    = blk_r;
    fcnt_nxt   = fcnt_r;
    fbytes_nxt = fbytes_r;
    res_st_nxt  = res_st_r;
    res_off_nxt = res_off_r;
    res_ord_nxt = res_ord_r;
    res_load   = 1'b0;
    cmd_pop    = 1'b0;
    fm_raddr   = fa_r;
    fm_we      = 1'b0;
    fm_waddr   = fa_r;
    fm_wdata   = fm_rdata_r;
    bi_raddr   = cur_r.unit;
    bi_we      = 1'b0;
    bi_waddr   = u_r;
    bi_wdata   = '0;
    unique case (state_r)
      bba_pkg::S_CLR: begin
        fm_waddr = bba_pkg::MAP_AW'(clr_r);
        fm_wdata = init_word(clr_r);
        fm_we    = int'(clr_r) < bba_pkg::MAP_WORDS;
        bi_waddr = bba_pkg::UNIT_W'(clr_r);
        bi_we    = int'(clr_r) < bba_pkg::UNITS;
        if (clr_r == bba_pkg::CLR_W'(bba_pkg::CLR_N - 1)) state_nxt = bba_pkg::S_IDLE;
        else clr_nxt = clr_r + 1'b1;
      end
      bba_pkg::S_IDLE: begin
        if (cmd_valid && !res_valid_r) begin
          cmd_pop   = 1'b1;
          cur_nxt   = cmd;
          state_nxt = bba_pkg::S_DISP;
        end
      end
      bba_pkg::S_DISP: begin
        res_st_nxt  = bba_pkg::ST_OK;
        res_off_nxt = '0;
        res_ord_nxt = '0;
        unique case (cur_r.kind)
          bba_pkg::CMD_ERR: begin
            res_st_nxt = cur_r.status;
            state_nxt  = bba_pkg::S_RES;
          end
          bba_pkg::CMD_ALLOC: begin
            if (!pick_found) begin
              res_st_nxt = bba_pkg::ST_OOM;
              state_nxt  = bba_pkg::S_RES;
            end else begin
              j_nxt     = pick_j;
              widx_nxt  = '0;
              state_nxt = bba_pkg::S_A_RD;
            end
          end
          bba_pkg::CMD_FREE: state_nxt = bba_pkg::S_F_INFO;
          default: state_nxt = bba_pkg::S_IDLE;
        endcase
      end
      bba_pkg::S_A_RD: begin
        fm_raddr  = bba_pkg::MAP_BASE[j_r] + widx_r;
        fa_nxt    = fm_raddr;
        state_nxt = bba_pkg::S_A_CHK;
      end
      bba_pkg::S_A_CHK: begin
        if (fm_rdata_r == '0) begin
          widx_nxt  = widx_r + 1'b1;
          state_nxt = bba_pkg::S_A_RD;
        end else begin
          fm_we        = 1'b1;
          fm_wdata     = fm_rdata_r & ~(bba_pkg::WORD_BITS'(1) << low_bit);
          u_nxt        = bba_pkg::UNIT_W'({widx_r, low_bit} << j_r);
          lvl_nxt[j_r] = lvl_r[j_r] - 1'b1;
          fcnt_nxt     = fcnt_r - 1'b1;
          fbytes_nxt   = fbytes_r - bba_pkg::net_bytes(j_r);
          state_nxt    = bba_pkg::S_A_SPLIT;
        end
      end
      bba_pkg::S_A_SPLIT: begin
        if (j_r > cur_r.order) begin
          j_nxt     = j_r - 1'b1;
          sk_nxt    = j_r - 1'b1;
          su_nxt    = u_r | (bba_pkg::UNIT_W'(1) << (j_r - 1'b1));
          blk_nxt   = blk_r + 1'b1;
          state_nxt = bba_pkg::S_SET_RD;
        end else begin
          bi_we       = 1'b1;
          bi_waddr    = u_r;
          bi_wdata    = {1'b1, cur_r.order};
          res_off_nxt = bba_pkg::OFF_W'(u_r) << bba_pkg::MIN_SHIFT;
          res_ord_nxt = cur_r.order;
          state_nxt   = bba_pkg::S_RES;
        end
      end
      bba_pkg::S_SET_RD: begin
        fm_raddr  = bba_pkg::map_word(sk_r, su_r);
        fa_nxt    = fm_raddr;
        fb_nxt    = bba_pkg::map_bit(sk_r, su_r);
        state_nxt = bba_pkg::S_SET_WR;
      end
      bba_pkg::S_SET_WR: begin
        fm_we         = 1'b1;
        fm_wdata      = fm_rdata_r | (bba_pkg::WORD_BITS'(1) << fb_r);
        lvl_nxt[sk_r] = lvl_r[sk_r] + 1'b1;
        fcnt_nxt      = fcnt_r + 1'b1;
        fbytes_nxt    = fbytes_r + bba_pkg::net_bytes(sk_r);
        if (cur_r.kind == bba_pkg::CMD_FREE) begin
          res_off_nxt = bba_pkg::OFF_W'(su_r) << bba_pkg::MIN_SHIFT;
          res_ord_nxt = sk_r;
          state_nxt   = bba_pkg::S_RES;
        end else begin
          state_nxt = bba_pkg::S_A_SPLIT;
        end
      end
      bba_pkg::S_F_INFO: begin
        if (!bi_rdata_r[bba_pkg::ORD_W] ||
            bi_rdata_r[bba_pkg::ORD_W-1:0] > bba_pkg::ORD_W'(bba_pkg::TOP_ORDER)) begin
          res_st_nxt = bba_pkg::ST_BADFREE;
          state_nxt  = bba_pkg::S_RES;
        end else begin
          j_nxt     = bi_rdata_r[bba_pkg::ORD_W-1:0];
          u_nxt     = cur_r.unit;
          bi_we     = 1'b1;
          bi_waddr  = cur_r.unit;
          bi_wdata  = '0;
          state_nxt = bba_pkg::S_F_LOOP;
        end
      end
      bba_pkg::S_F_LOOP: begin
        if (j_r < bba_pkg::ORD_W'(bba_pkg::TOP_ORDER)) begin
          fm_raddr  = bba_pkg::map_word(j_r, bud);
          fa_nxt    = fm_raddr;
          fb_nxt    = bba_pkg::map_bit(j_r, bud);
          state_nxt = bba_pkg::S_F_CHK;
        end else begin
          sk_nxt    = j_r;
          su_nxt    = u_r;
          state_nxt = bba_pkg::S_SET_RD;
        end
      end
      bba_pkg::S_F_CHK: begin
        if (fm_rdata_r[fb_r]) begin
          fm_we        = 1'b1;
          fm_wdata     = fm_rdata_r & ~(bba_pkg::WORD_BITS'(1) << fb_r);
          lvl_nxt[j_r] = lvl_r[j_r] - 1'b1;
          fcnt_nxt     = fcnt_r - 1'b1;
          fbytes_nxt   = fbytes_r - bba_pkg::net_bytes(j_r);
          blk_nxt      = blk_r - 1'b1;
          u_nxt        = u_r & ~(bba_pkg::UNIT_W'(1) << j_r);
          j_nxt        = j_r + 1'b1;
          state_nxt    = bba_pkg::S_F_LOOP;
        end else begin
          sk_nxt    = j_r;
          su_nxt    = u_r;
          state_nxt = bba_pkg::S_SET_RD;
        end
      end
      bba_pkg::S_RES: begin
        res_load  = 1'b1;
        state_nxt = bba_pkg::S_IDLE;
      end
      default: state_nxt = bba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (out_pop && res_valid_r) res_valid_nxt = 1'b0;
    if (res_load) res_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::S_CLR;
      clr_r       <= '0;
      res_valid_r <= 1'b0;
      blk_r       <= bba_pkg::CNT_W'(bba_pkg::TOP_BLOCKS);
      fcnt_r      <= bba_pkg::CNT_W'(bba_pkg::TOP_BLOCKS);
      fbytes_r    <= bba_pkg::BYTES_W'(bba_pkg::TOP_BLOCKS *
                     ((bba_pkg::MIN_BLOCK_BYTES << bba_pkg::TOP_ORDER) - bba_pkg::HEADER_BYTES));
      for (int k = 0; k <= bba_pkg::TOP_ORDER; k++) begin
        lvl_r[k] <= (k == bba_pkg::TOP_ORDER) ? bba_pkg::CNT_W'(bba_pkg::TOP_BLOCKS) : '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      res_valid_r <= res_valid_nxt;
      blk_r       <= blk_nxt;
      fcnt_r      <= fcnt_nxt;
      fbytes_r    <= fbytes_nxt;
      lvl_r       <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    j_r       <= j_nxt;
    sk_r      <= sk_nxt;
    widx_r    <= widx_nxt;
    fa_r      <= fa_nxt;
    u_r       <= u_nxt;
    su_r      <= su_nxt;
    fb_r      <= fb_nxt;
    res_st_r  <= res_st_nxt;
    res_off_r <= res_off_nxt;
    res_ord_r <= res_ord_nxt;
    if (res_load) begin
      res_blk_r    <= blk_r;
      res_fcnt_r   <= fcnt_r;
      res_fbytes_r <= fbytes_r;
    end
  end

  assign out_empty        = !res_valid_r;
  assign out_status       = res_st_r;
  assign out_block_offset = res_off_r;
  assign out_block_order  = res_ord_r;
  assign out_total_blocks = res_blk_r;
  assign out_free_cnt     = res_fcnt_r;
  assign out_free_total   = res_fbytes_r;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bba_pkg::S_CLR) |-> !cmd_pop)
    else $error("command taken during clearing pass");

  a_hit_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bba_pkg::S_A_CHK && fm_rdata_r != '0) |-> (fcnt_r != '0))
    else $error("free map hit with zero free count");

  a_result_from_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_valid_r) |-> $past(state_r == bba_pkg::S_RES))
    else $error("result raised outside result state");

  a_set_was_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bba_pkg::S_SET_WR) |-> !fm_rdata_r[fb_r])
    else $error("block freed twice in free map");

endmodule

// ===== src/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator: buddy memory allocator
// Queue-style request and result ports around a classifier and an engine.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over its memories; requests are
// queued (two deep) but not served until it ends. An allocation scans the
// 32-bit free map words at the chosen order from the lowest address, one read
// per word, and does one read-modify-write of the free map per split level.
// A free does one read-modify-write of the free map per coalesced level.
// Requests are served one at a time; results are held in one output register
// until popped.
module buddy_block_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_req_type,
  input  logic [bba_pkg::REQ_W-1:0]    in_request_bytes,
  input  logic [bba_pkg::OFF_W-1:0]    in_free_offset,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [2:0]                   out_status,
  output logic [bba_pkg::OFF_W-1:0]    out_block_offset,
  output logic [bba_pkg::ORD_W-1:0]    out_block_order,
  output logic [bba_pkg::CNT_W-1:0]    out_total_blocks,
  output logic [bba_pkg::CNT_W-1:0]    out_free_cnt,
  output logic [bba_pkg::BYTES_W-1:0]  out_free_total
);

  logic          cmd_valid;
  logic          cmd_pop;
  bba_pkg::cmd_t cmd;

  bba_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_req_type      (in_req_type),
    .in_request_bytes (in_request_bytes),
    .in_free_offset   (in_free_offset),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop)
  );

  bba_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_block_offset (out_block_offset),
    .out_block_order  (out_block_order),
    .out_total_blocks (out_total_blocks),
    .out_free_cnt     (out_free_cnt),
    .out_free_total   (out_free_total)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: buddy_block_allocator testbench
// Drives allocate and free requests through the queue ports with random
// push/pop gaps. A scoreboard keeps its own free map, block table and
// counters, predicts each result and checks it field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int N_UNITS = bba_pkg::TOP_BLOCKS << bba_pkg::TOP_ORDER;

  typedef struct packed {
    bba_pkg::status_t             status;
    logic [bba_pkg::OFF_W-1:0]    offset;
    logic [bba_pkg::ORD_W-1:0]    order;
    logic [bba_pkg::CNT_W-1:0]    total;
    logic [bba_pkg::CNT_W-1:0]    nfree;
    logic [bba_pkg::BYTES_W-1:0]  fbytes;
  } alloc_result_t;

  class alloc_scoreboard;
    bit                           free_bits [0:bba_pkg::TOP_ORDER][0:N_UNITS-1];
    logic [4:0]                   unit_tag [0:N_UNITS-1];
    logic [bba_pkg::CNT_W-1:0]    blk_cnt;
    logic [bba_pkg::CNT_W-1:0]    free_cnt;
    logic [bba_pkg::BYTES_W-1:0]  free_total;
    alloc_result_t                pending [$];
    logic [bba_pkg::OFF_W-1:0]    live [$];
    int                           errors;

    function new();
      for (int k = 0; k <= bba_pkg::TOP_ORDER; k++)
        for (int i = 0; i < N_UNITS; i++) free_bits[k][i] = 0;
      for (int i = 0; i < N_UNITS; i++) unit_tag[i] = '0;
      blk_cnt = bba_pkg::CNT_W'(bba_pkg::TOP_BLOCKS);
      free_cnt = 0;
      free_total = 0;
      errors = 0;
      for (int t = 0; t < bba_pkg::TOP_BLOCKS; t++)
        mark_free(bba_pkg::TOP_ORDER, t << bba_pkg::TOP_ORDER);
    endfunction

    function void mark_free(int k, int u);
      free_bits[k][u >> k] = 1;
      free_cnt++;
      free_total += bba_pkg::BYTES_W'((bba_pkg::MIN_BLOCK_BYTES << k) - bba_pkg::HEADER_BYTES);
    endfunction

    function void take_free(int k, int u);
      free_bits[k][u >> k] = 0;
      free_cnt--;
      free_total -= bba_pkg::BYTES_W'((bba_pkg::MIN_BLOCK_BYTES << k) - bba_pkg::HEADER_BYTES);
    endfunction

    function void note_request(logic rtype, logic [bba_pkg::REQ_W-1:0] nbytes,
                               logic [bba_pkg::OFF_W-1:0] foff);
      alloc_result_t r;
      int k, j, u, b, cnt;
      bit found;
      r = '0;
      r.status = bba_pkg::ST_OK;
      found = 0;
      u = 0;
      if (rtype == bba_pkg::REQ_ALLOC) begin
        if (nbytes == 0) r.status = bba_pkg::ST_ZERO;
        else if (nbytes > bba_pkg::SIZE_LIMIT) r.status = bba_pkg::ST_LARGE;
        else begin
          k = 0;
          while (k <= bba_pkg::TOP_ORDER &&
                 (bba_pkg::MIN_BLOCK_BYTES << k) < int'(nbytes) + bba_pkg::HEADER_BYTES) k++;
          if (k > bba_pkg::TOP_ORDER) r.status = bba_pkg::ST_LARGE;
          else begin
            for (j = k; j <= bba_pkg::TOP_ORDER; j++) begin
              cnt = bba_pkg::TOP_BLOCKS << (bba_pkg::TOP_ORDER - j);
              for (int i = 0; i < cnt; i++)
                if (free_bits[j][i]) begin
                  u = i << j;
                  found = 1;
                  break;
                end
              if (found) break;
            end
            if (!found) r.status = bba_pkg::ST_OOM;
            else begin
              take_free(j, u);
              while (j > k) begin
                j--;
                mark_free(j, u + (1 << j));
                blk_cnt++;
              end
              unit_tag[u] = {1'b1, 4'(k)};
              r.offset = bba_pkg::OFF_W'(u * bba_pkg::MIN_BLOCK_BYTES);
              r.order = bba_pkg::ORD_W'(k);
              live.push_back(r.offset);
            end
          end
        end
      end else begin
        u = int'(foff) / bba_pkg::MIN_BLOCK_BYTES;
        if ((foff % bba_pkg::MIN_BLOCK_BYTES) != 0 || u >= N_UNITS || !unit_tag[u][4]
            || unit_tag[u][3:0] > bba_pkg::TOP_ORDER)
          r.status = bba_pkg::ST_BADFREE;
        else begin
          k = unit_tag[u][3:0];
          unit_tag[u] = '0;
          foreach (live[i])
            if (live[i] == foff) begin
              live.delete(i);
              break;
            end
          while (k < bba_pkg::TOP_ORDER) begin
            b = u ^ (1 << k);
            if (!free_bits[k][b >> k]) break;
            take_free(k, b);
            blk_cnt--;
            if (b < u) u = b;
            k++;
          end
          mark_free(k, u);
          r.offset = bba_pkg::OFF_W'(u * bba_pkg::MIN_BLOCK_BYTES);
          r.order = bba_pkg::ORD_W'(k);
        end
      end
      r.total = blk_cnt;
      r.nfree = free_cnt;
      r.fbytes = free_total;
      pending.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, got.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.offset !== e.offset) begin
        $display("%0t: offset exp %0d got %0d", $time, e.offset, got.offset);
        errors++;
      end
      if (got.order !== e.order) begin
        $display("%0t: order exp %0d got %0d", $time, e.order, got.order);
        errors++;
      end
      if (got.total !== e.total) begin
        $display("%0t: total blocks exp %0d got %0d", $time, e.total, got.total);
        errors++;
      end
      if (got.nfree !== e.nfree) begin
        $display("%0t: free count exp %0d got %0d", $time, e.nfree, got.nfree);
        errors++;
      end
      if (got.fbytes !== e.fbytes) begin
        $display("%0t: free total exp %0d got %0d", $time, e.fbytes, got.fbytes);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_push;
  logic                          in_full;
  logic                          in_req_type;
  logic [bba_pkg::REQ_W-1:0]     in_request_bytes;
  logic [bba_pkg::OFF_W-1:0]     in_free_offset;
  logic                          out_empty;
  logic                          out_pop;
  logic [2:0]                    out_status;
  logic [bba_pkg::OFF_W-1:0]     out_block_offset;
  logic [bba_pkg::ORD_W-1:0]     out_block_order;
  logic [bba_pkg::CNT_W-1:0]     out_total_blocks;
  logic [bba_pkg::CNT_W-1:0]     out_free_cnt;
  logic [bba_pkg::BYTES_W-1:0]   out_free_total;

  alloc_scoreboard sb;
  int  sent;
  bit  quiet;
  logic [bba_pkg::OFF_W-1:0] last_freed;

  buddy_block_allocator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_req_type      (in_req_type),
    .in_request_bytes (in_request_bytes),
    .in_free_offset   (in_free_offset),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_block_offset (out_block_offset),
    .out_block_order  (out_block_order),
    .out_total_blocks (out_total_blocks),
    .out_free_cnt     (out_free_cnt),
    .out_free_total   (out_free_total)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 12000000);
    $display("tb_top failed");
    $finish;
  end

  // entered and left at a falling edge; push stays high on return
  task automatic send_request(logic rtype, logic [bba_pkg::REQ_W-1:0] nbytes,
                              logic [bba_pkg::OFF_W-1:0] foff);
    bit done;
    done = 0;
    while (!quiet && $urandom_range(0, 99) < 17) begin
      in_push <= 0;
      @(negedge clk);
    end
    in_push <= 1;
    in_req_type <= rtype;
    in_request_bytes <= nbytes;
    in_free_offset <= foff;
    while (!done) begin
      @(posedge clk);
      if (!in_full) begin
        done = 1;
        sb.note_request(rtype, nbytes, foff);
        if (rtype == bba_pkg::REQ_FREE) last_freed = foff;
      end
      @(negedge clk);
    end
    sent++;
  endtask

  task automatic free_live(int idx);
    send_request(bba_pkg::REQ_FREE, '0, sb.live[idx]);
  endtask

  task automatic random_request(bit filling);
    int o, p;
    p = $urandom_range(0, 99);
    if (p < 8) begin
      case ($urandom_range(0, 4))
        0: send_request(bba_pkg::REQ_ALLOC, '0, bba_pkg::OFF_W'($urandom()));
        1: send_request(bba_pkg::REQ_ALLOC, bba_pkg::REQ_W'($urandom()),
                        bba_pkg::OFF_W'($urandom()));
        2: send_request(bba_pkg::REQ_FREE, bba_pkg::REQ_W'($urandom()),
                        bba_pkg::OFF_W'($urandom()));
        3: send_request(bba_pkg::REQ_FREE, bba_pkg::REQ_W'($urandom()), last_freed);
        default: send_request(bba_pkg::REQ_FREE, bba_pkg::REQ_W'($urandom()),
                              bba_pkg::OFF_W'($urandom_range(0, N_UNITS - 1) *
                                              bba_pkg::MIN_BLOCK_BYTES));
      endcase
    end else if (sb.live.size() > 0 && p < (filling ? 35 : 75)) begin
      free_live($urandom_range(0, sb.live.size() - 1));
    end else begin
      if ($urandom_range(0, 3) == 0) o = $urandom_range(6, bba_pkg::TOP_ORDER);
      else o = $urandom_range(0, 4);
      send_request(bba_pkg::REQ_ALLOC,
                   bba_pkg::REQ_W'($urandom_range(1, (bba_pkg::MIN_BLOCK_BYTES << o) -
                                                     bba_pkg::HEADER_BYTES)),
                   bba_pkg::OFF_W'($urandom()));
    end
  endtask

  initial begin
    sb = new();
    sent = 0;
    quiet = 0;
    last_freed = '0;
    rst_n = 0;
    in_push = 0;
    in_req_type = bba_pkg::REQ_ALLOC;
    in_request_bytes = '0;
    in_free_offset = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    send_request(bba_pkg::REQ_ALLOC, '0, '0);
    send_request(bba_pkg::REQ_ALLOC, bba_pkg::REQ_W'(bba_pkg::SIZE_LIMIT + 1), '1);
    send_request(bba_pkg::REQ_ALLOC, '1, '0);
    send_request(bba_pkg::REQ_ALLOC, bba_pkg::REQ_W'(bba_pkg::SIZE_LIMIT), '0);
    send_request(bba_pkg::REQ_ALLOC,
                 bba_pkg::REQ_W'((bba_pkg::MIN_BLOCK_BYTES << bba_pkg::TOP_ORDER) -
                                 bba_pkg::HEADER_BYTES + 1), '0);
    send_request(bba_pkg::REQ_ALLOC,
                 bba_pkg::REQ_W'((bba_pkg::MIN_BLOCK_BYTES << bba_pkg::TOP_ORDER) -
                                 bba_pkg::HEADER_BYTES), '0);
    send_request(bba_pkg::REQ_ALLOC, bba_pkg::REQ_W'(1), '0);
    send_request(bba_pkg::REQ_ALLOC,
                 bba_pkg::REQ_W'(bba_pkg::MIN_BLOCK_BYTES - bba_pkg::HEADER_BYTES), '0);
    send_request(bba_pkg::REQ_ALLOC,
                 bba_pkg::REQ_W'(bba_pkg::MIN_BLOCK_BYTES - bba_pkg::HEADER_BYTES + 1), '0);
    send_request(bba_pkg::REQ_FREE, '0, bba_pkg::OFF_W'(bba_pkg::MIN_BLOCK_BYTES / 2));
    send_request(bba_pkg::REQ_FREE, '0, bba_pkg::OFF_W'(bba_pkg::MIN_BLOCK_BYTES));
    send_request(bba_pkg::REQ_FREE, '0, '1);
    send_request(bba_pkg::REQ_FREE, '0,
                 bba_pkg::OFF_W'((N_UNITS - 1) * bba_pkg::MIN_BLOCK_BYTES));
    free_live(1);
    send_request(bba_pkg::REQ_FREE, '0, last_freed);
    free_live(sb.live.size() - 1);
    free_live(0);
    free_live(0);

    for (int i = 0; i < 760; i++) begin
      quiet = (i >= 300 && i < 450);
      random_request(((i / 120) % 2) == 0);
    end
    quiet = 0;
    in_push <= 0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    out_pop = 0;
    forever begin
      @(negedge clk);
      out_pop <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 17);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_result('{bba_pkg::status_t'(out_status), out_block_offset, out_block_order,
                        out_total_blocks, out_free_cnt, out_free_total});
  end

endmodule

// ===== filelist.f =====
src/bba_pkg.sv
src/bba_front.sv
src/bba_back.sv
src/buddy_block_allocator.sv
tb/tb_top.sv
